[rtl/bth_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bth_pkg;

  localparam int TIME_W = 48;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_EXPIRE = 2'd2,
    CMD_NOP    = 2'd3
  } bth_cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_ARMED = 3'd1,
    ST_NO_BUCKET = 3'd2,
    ST_FIRED     = 3'd3,
    ST_NONE_DUE  = 3'd4
  } bth_status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_URD, S_ULINK, S_UCHK, S_UKEY, S_DROP, S_SUP, S_SDN,
    S_SRCH, S_AWR, S_ALINK, S_AHEAP, S_FIN
  } bth_state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DEC, OP_ULINK, OP_UKEY, OP_DROP, OP_SUP, OP_SDN,
    OP_SRCH, OP_AWR, OP_ALINK, OP_AHEAP, OP_OUT
  } bth_op_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [5:0]        timer_id;
    logic [31:0]       duration_ms;
    logic [TIME_W-1:0] now_ms;
  } bth_in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [5:0]        fired_id;
    logic              next_valid;
    logic [5:0]        next_id;
    logic [TIME_W-1:0] next_deadline;
  } bth_out_t;

  typedef struct packed {
    bth_cmd_e cmd;
    logic     id_ok;
    logic     armed;
    logic     empty;
    logic     due;
    logic     wo;
    logic     p_nil;
    logic     pos_last;
    logic     sup_move;
    logic     sdn_move;
    logic     moved;
    logic     srch_ok;
    logic     fresh;
    logic     nw_nil;
    logic     out_free;
  } bth_sts_t;

endpackage
`default_nettype wire

[rtl/bucketed_timeout_heap.sv]
// A command that changes nothing goes straight to the result;
// a rearm may drop a bucket and re-sift it in the heap.
// One command at a time; the next can be accepted in the cycle after the result is registered.
// The heap sift moves one level per cycle.
// The result register lets the next command be accepted while a result waits.
// Reset clears armed flags, bucket in-use flags, heap count, output valid and the sequencer;
// timer memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module bucketed_timeout_heap import bth_pkg::*; #(
  parameter int NumTimers  = 64,
  parameter int NumBuckets = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire bth_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output bth_out_t     out_data_o
);

  bth_op_e  op;
  bth_sts_t sts;

  bth_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .op_o       (op)
  );

  bth_dp #(
    .NumTimers  (NumTimers),
    .NumBuckets (NumBuckets)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .in_data_i   (in_data_i),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

[rtl/bth_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module bth_dp import bth_pkg::*; #(
  parameter int NumTimers  = 64,
  parameter int NumBuckets = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire bth_op_e  op_i,
  input  wire bth_in_t  in_data_i,
  output bth_sts_t      sts_o,
  input  wire logic     out_ready_i,
  output logic          out_valid_o,
  output bth_out_t      out_data_o
);

  localparam int TidW = $clog2(NumTimers);
  localparam int LnkW = $clog2(NumTimers + 1);
  localparam int BktW = $clog2(NumBuckets);
  localparam int CntW = $clog2(NumBuckets + 1);
  localparam logic [LnkW-1:0] Nil = LnkW'(NumTimers);

  // request and scratch
  bth_in_t           req_q;
  logic [TidW-1:0]   ut_q;
  logic [2:0]        status_q;
  logic [5:0]        fired_q;
  logic [BktW-1:0]   ub_q, pos_q, eb_q, fb_q;
  logic [LnkW-1:0]   p_q, nw_q;
  logic [TIME_W-1:0] ek_q, sum_q;
  logic              wo_q, moved_q, fresh_q;

  // control state
  logic              armed_q [NumTimers];
  logic              buse_q  [NumBuckets];
  logic [CntW-1:0]   cnt_q;
  logic              out_valid_q;
  bth_out_t          out_q;

  // bucket and heap registers
  logic [31:0]       bdur_q [NumBuckets];
  logic [LnkW-1:0]   bo_q   [NumBuckets];
  logic [LnkW-1:0]   bn_q   [NumBuckets];
  logic [BktW-1:0]   bidx_q [NumBuckets];
  logic [BktW-1:0]   hb_q   [NumBuckets];
  logic [TIME_W-1:0] hk_q   [NumBuckets];

  // per-timer memories
  logic [TIME_W-1:0] tdl_mem  [NumTimers];
  logic [BktW-1:0]   tow_mem  [NumTimers];
  logic [LnkW-1:0]   tprv_mem [NumTimers];
  logic [LnkW-1:0]   tnxt_mem [NumTimers];
  logic [TIME_W-1:0] tdl_rd;
  logic [BktW-1:0]   tow_rd;
  logic [LnkW-1:0]   tprv_rd, tnxt_rd;

  bth_cmd_e          cmd;
  logic [TidW-1:0]   t_in;
  logic              id_ok, empty, due;
  logic [LnkW-1:0]   top_t;
  bth_status_e       dec_status;
  logic [BktW-1:0]   par, last, cs;
  logic              sup_move, sdn_move;
  logic [BktW:0]     cw, rw;
  logic              c_ok, r_ok, pick_r;
  logic              found_any, free_any;
  logic [BktW-1:0]   found_b, free_b;
  logic [TIME_W:0]   sum_w;
  logic [TIME_W-1:0] sum_sat;
  bth_out_t          out_d;

  assign cmd   = bth_cmd_e'(req_q.command);
  assign t_in  = TidW'(req_q.timer_id);
  assign id_ok = int'(req_q.timer_id) < NumTimers;
  assign empty = (cnt_q == '0);
  assign top_t = bo_q[hb_q[0]];
  assign due   = hk_q[0] <= req_q.now_ms;
  assign last  = BktW'(cnt_q - CntW'(1));

  always_comb begin
    case (cmd)
      CMD_ADD:    dec_status = id_ok ? ST_OK : ST_NOT_ARMED;
      CMD_REMOVE: dec_status = (id_ok && armed_q[t_in]) ? ST_OK : ST_NOT_ARMED;
      CMD_EXPIRE: dec_status = (!empty && due) ? ST_FIRED : ST_NONE_DUE;
      default:    dec_status = ST_OK;
    endcase
  end

  // heap step: parent is (pos-1)>>1, children 2pos+1 and 2pos+2
  assign par      = (pos_q - BktW'(1)) >> 1;
  assign sup_move = (pos_q != '0) && (ek_q < hk_q[par]);
  assign cw       = {pos_q, 1'b1};
  assign rw       = cw + (BktW+1)'(1);
  assign c_ok     = cw < (BktW+1)'(cnt_q);
  assign r_ok     = rw < (BktW+1)'(cnt_q);
  assign pick_r   = r_ok && (hk_q[cw[BktW-1:0]] > hk_q[rw[BktW-1:0]]);
  assign cs       = pick_r ? rw[BktW-1:0] : cw[BktW-1:0];
  assign sdn_move = c_ok && (hk_q[cs] < ek_q);

  always_comb begin
    found_any = 1'b0;
    free_any  = 1'b0;
    found_b   = '0;
    free_b    = '0;
    for (int i = 0; i < NumBuckets; i++) begin
      if (buse_q[i]) begin
        if (bdur_q[i] == req_q.duration_ms && !found_any) begin
          found_any = 1'b1;
          found_b   = BktW'(i);
        end
      end else if (!free_any) begin
        free_any = 1'b1;
        free_b   = BktW'(i);
      end
    end
  end

  // deadline saturates at all ones
  assign sum_w   = {1'b0, req_q.now_ms} + (TIME_W+1)'(req_q.duration_ms);
  assign sum_sat = sum_w[TIME_W] ? '1 : sum_w[TIME_W-1:0];

  always_comb begin
    out_d.status        = status_q;
    out_d.fired_id      = fired_q;
    out_d.next_valid    = !empty;
    out_d.next_id       = empty ? 6'd0 : 6'(top_t);
    out_d.next_deadline = empty ? '0 : hk_q[0];
  end

  always_comb begin
    sts_o.cmd      = cmd;
    sts_o.id_ok    = id_ok;
    sts_o.armed    = armed_q[t_in];
    sts_o.empty    = empty;
    sts_o.due      = due;
    sts_o.wo       = wo_q;
    sts_o.p_nil    = (p_q == Nil);
    sts_o.pos_last = (CntW'(pos_q) == cnt_q - CntW'(1));
    sts_o.sup_move = sup_move;
    sts_o.sdn_move = sdn_move;
    sts_o.moved    = moved_q;
    sts_o.srch_ok  = found_any | free_any;
    sts_o.fresh    = fresh_q;
    sts_o.nw_nil   = (nw_q == Nil);
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    tdl_rd  <= tdl_mem[p_q[TidW-1:0]];
    tow_rd  <= tow_mem[ut_q];
    tprv_rd <= tprv_mem[ut_q];
    tnxt_rd <= tnxt_mem[ut_q];
    case (op_i)
      OP_ULINK: begin
        if (tprv_rd != Nil) tnxt_mem[tprv_rd[TidW-1:0]] <= tnxt_rd;
        if (tnxt_rd != Nil) tprv_mem[tnxt_rd[TidW-1:0]] <= tprv_rd;
      end
      OP_AWR: begin
        tdl_mem[ut_q]  <= sum_q;
        tow_mem[ut_q]  <= fb_q;
        tprv_mem[ut_q] <= Nil;
        tnxt_mem[ut_q] <= nw_q;
      end
      OP_ALINK: tprv_mem[nw_q[TidW-1:0]] <= LnkW'(ut_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: req_q <= in_data_i;
      OP_DEC: begin
        ut_q     <= (cmd == CMD_EXPIRE) ? top_t[TidW-1:0] : t_in;
        status_q <= dec_status;
        fired_q  <= (dec_status == ST_FIRED) ? 6'(top_t) : 6'd0;
      end
      OP_ULINK: begin
        ub_q  <= tow_rd;
        p_q   <= tprv_rd;
        pos_q <= bidx_q[tow_rd];
        wo_q  <= (bo_q[tow_rd] == LnkW'(ut_q));
        if (tprv_rd == Nil) bn_q[tow_rd] <= tnxt_rd;
        if (tnxt_rd == Nil) bo_q[tow_rd] <= tprv_rd;
      end
      OP_UKEY: begin
        eb_q    <= ub_q;
        ek_q    <= tdl_rd;
        moved_q <= 1'b0;
      end
      OP_DROP: begin
        eb_q    <= hb_q[last];
        ek_q    <= hk_q[last];
        moved_q <= 1'b0;
      end
      OP_SUP: begin
        if (sup_move) begin
          hb_q[pos_q]       <= hb_q[par];
          hk_q[pos_q]       <= hk_q[par];
          bidx_q[hb_q[par]] <= pos_q;
          pos_q             <= par;
          moved_q           <= 1'b1;
        end else begin
          hb_q[pos_q]  <= eb_q;
          hk_q[pos_q]  <= ek_q;
          bidx_q[eb_q] <= pos_q;
        end
      end
      OP_SDN: begin
        if (sdn_move) begin
          hb_q[pos_q]      <= hb_q[cs];
          hk_q[pos_q]      <= hk_q[cs];
          bidx_q[hb_q[cs]] <= pos_q;
          pos_q            <= cs;
        end else begin
          hb_q[pos_q]  <= eb_q;
          hk_q[pos_q]  <= ek_q;
          bidx_q[eb_q] <= pos_q;
        end
      end
      OP_SRCH: begin
        fb_q    <= found_any ? found_b : free_b;
        fresh_q <= !found_any;
        nw_q    <= found_any ? bn_q[found_b] : Nil;
        sum_q   <= sum_sat;
        if (!(found_any || free_any)) status_q <= ST_NO_BUCKET;
      end
      OP_AWR: begin
        bdur_q[fb_q] <= req_q.duration_ms;
        bn_q[fb_q]   <= LnkW'(ut_q);
        if (nw_q == Nil) bo_q[fb_q] <= LnkW'(ut_q);
      end
      OP_AHEAP: begin
        hb_q[last + BktW'(1)] <= fb_q;
        hk_q[last + BktW'(1)] <= sum_q;
        bidx_q[fb_q]          <= BktW'(cnt_q);
        eb_q                  <= fb_q;
        ek_q                  <= sum_q;
        pos_q                 <= BktW'(cnt_q);
        moved_q               <= 1'b0;
      end
      OP_OUT: out_q <= out_d;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumTimers; i++) armed_q[i] <= 1'b0;
      for (int i = 0; i < NumBuckets; i++) buse_q[i] <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (op_i)
        OP_ULINK: armed_q[ut_q] <= 1'b0;
        OP_DROP: begin
          cnt_q        <= cnt_q - CntW'(1);
          buse_q[ub_q] <= 1'b0;
        end
        OP_AWR: begin
          armed_q[ut_q] <= 1'b1;
          buse_q[fb_q]  <= 1'b1;
        end
        OP_AHEAP: cnt_q <= cnt_q + CntW'(1);
        default: ;
      endcase
      if (op_i == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

[rtl/bth_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module bth_ctrl import bth_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire bth_sts_t sts_i,
  output bth_op_e       op_o
);

  bth_state_e state_q, state_d;
  logic       ret_add_q, ret_add_d;
  logic       up_only_q, up_only_d;
  bth_state_e unl_done;

  // where an unlink ends: back into the add, or straight to the result
  assign unl_done = ret_add_q ? S_SRCH : S_FIN;

  always_comb begin
    state_d   = state_q;
    ret_add_d = ret_add_q;
    up_only_d = up_only_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_DEC;
      S_DEC: begin
        ret_add_d = 1'b0;
        up_only_d = 1'b0;
        case (sts_i.cmd)
          CMD_ADD: begin
            if (!sts_i.id_ok) begin
              state_d = S_FIN;
            end else if (sts_i.armed) begin
              ret_add_d = 1'b1;
              state_d   = S_URD;
            end else begin
              state_d = S_SRCH;
            end
          end
          CMD_REMOVE: state_d = (sts_i.id_ok && sts_i.armed) ? S_URD : S_FIN;
          CMD_EXPIRE: state_d = (!sts_i.empty && sts_i.due) ? S_URD : S_FIN;
          default:    state_d = S_FIN;
        endcase
      end
      S_URD:   state_d = S_ULINK;
      S_ULINK: state_d = S_UCHK;
      S_UCHK: begin
        if (!sts_i.wo) begin
          state_d = unl_done;
        end else if (sts_i.p_nil) begin
          state_d = S_DROP;
        end else begin
          state_d = S_UKEY;
        end
      end
      S_UKEY: state_d = S_SUP;
      S_DROP: state_d = sts_i.pos_last ? unl_done : S_SUP;
      S_SUP: begin
        if (!sts_i.sup_move) begin
          state_d = (sts_i.moved || up_only_q) ? unl_done : S_SDN;
        end
      end
      S_SDN: if (!sts_i.sdn_move) state_d = unl_done;
      S_SRCH: begin
        ret_add_d = 1'b0;
        state_d   = sts_i.srch_ok ? S_AWR : S_FIN;
      end
      S_AWR: begin
        if (!sts_i.nw_nil) begin
          state_d = S_ALINK;
        end else if (sts_i.fresh) begin
          state_d = S_AHEAP;
        end else begin
          state_d = S_FIN;
        end
      end
      S_ALINK: state_d = S_FIN;
      S_AHEAP: begin
        up_only_d = 1'b1;
        state_d   = S_SUP;
      end
      S_FIN: if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    op_o       = OP_NONE;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) op_o = OP_LOAD;
      end
      S_DEC:   op_o = OP_DEC;
      S_ULINK: op_o = OP_ULINK;
      S_UKEY:  op_o = OP_UKEY;
      S_DROP:  op_o = OP_DROP;
      S_SUP:   op_o = OP_SUP;
      S_SDN:   op_o = OP_SDN;
      S_SRCH:  op_o = OP_SRCH;
      S_AWR:   op_o = OP_AWR;
      S_ALINK: op_o = OP_ALINK;
      S_AHEAP: op_o = OP_AHEAP;
      S_FIN:   op_o = sts_i.out_free ? OP_OUT : OP_NONE;
      default: op_o = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_add_q <= 1'b0;
      up_only_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_add_q <= ret_add_d;
      up_only_q <= up_only_d;
    end
  end

endmodule
`default_nettype wire
